// ----- sv/assert_macros.svh -----
// Assertion macros shared by the decoder RTL.
// Depends on nothing; the using module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/mrifd_pkg.sv -----
// Types and constants for the MIPS I instruction field decoder.
// Depends on nothing; used by mrifd_decode and the core top level.
`timescale 1ns / 1ps

package mrifd_pkg;

  // Primary opcodes and opcode groups
  localparam logic [5:0] OP_SPECIAL = 6'b000000;
  localparam logic [5:0] OP_REGIMM  = 6'b000001;
  localparam logic [5:0] OP_LUI     = 6'b001111;
  localparam logic [4:0] GRP_JUMP   = 5'b00001;  // op[5:1]: j, jal
  localparam logic [4:0] GRP_BEQNE  = 5'b00010;  // op[5:1]: beq, bne
  localparam logic [4:0] GRP_BLGZ   = 5'b00011;  // op[5:1]: blez, bgtz
  localparam logic [2:0] GRP_ALUIMM = 3'b001;    // op[5:3]
  localparam logic [2:0] GRP_LOAD   = 3'b100;
  localparam logic [2:0] GRP_STORE  = 3'b101;
  localparam logic [3:0] GRP_COP    = 4'b0100;   // op[5:2]
  localparam logic [2:0] GRP_LWC    = 3'b110;
  localparam logic [2:0] GRP_SWC    = 3'b111;

  // SPECIAL function codes
  localparam logic [5:0] FN_JR   = 6'b001000;
  localparam logic [5:0] FN_JALR = 6'b001001;

  // SPECIAL function-code groups, matched on the bit ranges noted
  localparam logic [3:0] FN_SHIFT_IMM = 4'b0000;  // fn[5:2]
  localparam logic [2:0] FN_SHIFT_REG = 3'b000;   // fn[5:3]
  localparam logic [4:0] FN_SYSTRAP   = 5'b00110; // fn[5:1]: syscall, break
  localparam logic [3:0] FN_HILO      = 4'b0100;  // fn[5:2], fn[0] set: move to
  localparam logic [3:0] FN_MULDIV    = 4'b0110;  // fn[5:2]

  // Coprocessor rs code for branch on condition
  localparam logic [4:0] COP_BC = 5'b01000;

  // Coprocessor rs groups, matched on rs[4:2]
  localparam logic [2:0] COP_MOVE_FROM = 3'b000;
  localparam logic [2:0] COP_MOVE_TO   = 3'b001;

  // Memory access kinds
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  localparam logic [2:0] WB_CPU   = 3'd4;
  localparam logic [5:0] PC_INDEX = 6'd32;

  typedef struct packed {
    logic [31:0] instruction_word;
    logic [31:0] instruction_address;
  } req_t;

  typedef struct packed {
    logic [31:0] current_address;
    logic [5:0]  primary_op;
    logic [5:0]  secondary_op;
    logic [1:0]  mem_access;
    logic [2:0]  write_back_target;
    logic [5:0]  left_reg;
    logic [4:0]  right_reg;
    logic [5:0]  dest_reg;
    logic [4:0]  link_dest_reg;
    logic [4:0]  function_select;
    logic [31:0] immediate;
  } res_t;

endpackage

// ----- sv/mrifd_decode.sv -----
// Combinational field split of one MIPS I instruction word.
// Depends on mrifd_pkg for the request/result types and opcode constants.
`timescale 1ns / 1ps

module mrifd_decode (
  input  mrifd_pkg::req_t req,
  output mrifd_pkg::res_t res
);

  logic [31:0] w;
  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [31:0] imm_sext;
  logic [31:0] imm_zext;

  assign w        = req.instruction_word;
  assign op       = w[31:26];
  assign fn       = w[5:0];
  assign rs       = w[25:21];
  assign rt       = w[20:16];
  assign rd       = w[15:11];
  assign imm_sext = {{16{w[15]}}, w[15:0]};
  assign imm_zext = {16'd0, w[15:0]};

  always_comb begin
    res                   = '0;
    res.current_address   = req.instruction_address;
    res.primary_op        = op;
    res.secondary_op      = fn;
    res.mem_access        = mrifd_pkg::MEM_NONE;
    res.write_back_target = mrifd_pkg::WB_CPU;

    if (op == mrifd_pkg::OP_SPECIAL) begin
      if (fn[5:2] == mrifd_pkg::FN_SHIFT_IMM) begin
        // shift by immediate amount
        res.immediate = {27'd0, w[10:6]};
        res.right_reg = rt;
        res.dest_reg  = {1'b0, rd};
      end else if (fn[5:3] == mrifd_pkg::FN_SHIFT_REG) begin
        res.left_reg  = {1'b0, rs};
        res.right_reg = rt;
        res.dest_reg  = {1'b0, rd};
      end else if (fn == mrifd_pkg::FN_JR) begin
        res.left_reg = {1'b0, rs};
        res.dest_reg = mrifd_pkg::PC_INDEX;
      end else if (fn == mrifd_pkg::FN_JALR) begin
        res.left_reg      = {1'b0, rs};
        res.dest_reg      = mrifd_pkg::PC_INDEX;
        res.link_dest_reg = rd;
      end else if (fn[5:1] == mrifd_pkg::FN_SYSTRAP) begin
        // syscall / break code
        res.immediate = {12'd0, w[25:6]};
      end else if (fn[5:2] == mrifd_pkg::FN_HILO && !fn[0]) begin
        res.dest_reg = {1'b0, rd};
      end else if (fn[5:2] == mrifd_pkg::FN_HILO) begin
        res.left_reg = {1'b0, rs};
      end else if (fn[5:2] == mrifd_pkg::FN_MULDIV) begin
        res.left_reg  = {1'b0, rs};
        res.right_reg = rt;
      end else if (fn[5]) begin
        res.left_reg  = {1'b0, rs};
        res.right_reg = rt;
        res.dest_reg  = {1'b0, rd};
      end
    end else if (op == mrifd_pkg::OP_REGIMM) begin
      res.left_reg        = {1'b0, rs};
      res.function_select = rt;
      res.immediate       = imm_sext;
    end else if (op[5:1] == mrifd_pkg::GRP_JUMP) begin
      res.immediate = {6'd0, w[25:0]};
      res.dest_reg  = mrifd_pkg::PC_INDEX;
    end else if (op[5:1] == mrifd_pkg::GRP_BEQNE) begin
      res.left_reg  = {1'b0, rs};
      res.right_reg = rt;
      res.immediate = imm_sext;
    end else if (op[5:1] == mrifd_pkg::GRP_BLGZ) begin
      res.left_reg  = {1'b0, rs};
      res.immediate = imm_sext;
    end else if (op == mrifd_pkg::OP_LUI) begin
      res.immediate = imm_zext;
      res.dest_reg  = {1'b0, rt};
    end else if (op[5:3] == mrifd_pkg::GRP_ALUIMM) begin
      res.left_reg  = {1'b0, rs};
      res.immediate = imm_sext;
      res.dest_reg  = {1'b0, rt};
    end else if (op[5:3] == mrifd_pkg::GRP_LOAD) begin
      res.left_reg   = {1'b0, rs};
      res.immediate  = imm_zext;
      res.dest_reg   = {1'b0, rt};
      res.mem_access = mrifd_pkg::MEM_READ;
    end else if (op[5:3] == mrifd_pkg::GRP_STORE) begin
      res.left_reg   = {1'b0, rs};
      res.right_reg  = rt;
      res.immediate  = imm_zext;
      res.mem_access = mrifd_pkg::MEM_WRITE;
    end else if (op[5:2] == mrifd_pkg::GRP_COP) begin
      res.function_select = rs;
      if (rs[4:2] == mrifd_pkg::COP_MOVE_FROM) begin
        // mfc / cfc: control moves read rd + 32
        res.dest_reg = {1'b0, rt};
        res.left_reg = {rs[1], rd};
      end else if (rs[4:2] == mrifd_pkg::COP_MOVE_TO) begin
        // mtc / ctc
        res.write_back_target = op[2:0];
        res.dest_reg          = {rs[1], rd};
        res.left_reg          = {1'b0, rt};
      end else if (rs == mrifd_pkg::COP_BC) begin
        res.right_reg = rt;
        res.immediate = imm_sext;
      end else if (rs[4]) begin
        res.immediate = {7'd0, w[24:0]};
      end
    end else if (op[5:3] == mrifd_pkg::GRP_LWC) begin
      res.write_back_target = op[2:0];
      res.left_reg          = {1'b0, rs};
      res.dest_reg          = {1'b0, rt};
      res.immediate         = imm_zext;
      res.mem_access        = mrifd_pkg::MEM_READ;
    end else if (op[5:3] == mrifd_pkg::GRP_SWC) begin
      res.left_reg   = {1'b0, rs};
      res.right_reg  = rt;
      res.immediate  = imm_zext;
      res.mem_access = mrifd_pkg::MEM_WRITE;
    end
  end

endmodule

// ----- sv/mips_r3000_instruction_field_decoder_core.sv -----
// Path: a request taken into the input register goes through one decode pass into
// the result register, with result_valid high for a single cycle per result.
// Throughput: one request per cycle; busy is low in every cycle after reset.
// Reset: rst (synchronous) clears both valid flags and holds busy high
// until the first edge with rst low.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mips_r3000_instruction_field_decoder_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  mrifd_pkg::req_t request,
  output logic            result_valid,
  output mrifd_pkg::res_t result
);

  mrifd_pkg::req_t req_q;
  logic            req_valid;
  mrifd_pkg::res_t dec;

  mrifd_decode u_decode (
    .req (req_q),
    .res (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b1;
      req_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      busy         <= 1'b0;
      req_valid    <= start && !busy;
      result_valid <= req_valid;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= request;
    end
    if (req_valid) begin
      result <= dec;
    end
  end

  `CHK_NEXT(a_accept_flows, start && !busy, req_valid, "accepted request lost")
  `CHK_NEXT(a_no_phantom, !req_valid, !result_valid, "result without request")
  `CHK_NOW(a_addr_copy, result_valid && $past(result_valid, 1) == 1'b0 && $past(start, 2),
    result.current_address == $past(request.instruction_address, 2),
    "address not carried through")
  `CHK_NOW(a_opcode_copy, result_valid && $past(start, 2),
    result.primary_op == $past(request.instruction_word[31:26], 2),
    "primary opcode mismatch")
  `CHK_NOW(a_mem_kind, result_valid,
    result.mem_access == mrifd_pkg::MEM_NONE || result.mem_access == mrifd_pkg::MEM_READ ||
    result.mem_access == mrifd_pkg::MEM_WRITE, "bad memory access kind")

endmodule
